/* rtl/julia_escape_time_defines.svh */
// ----------------------------------------------------------------------------
// Julia escape-time assertion macros
// Shared property shorthands for the block's checker.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_DEFINES_SVH
`define JULIA_ESCAPE_TIME_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define JET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define JET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jet_pkg.sv */
// ----------------------------------------------------------------------------
// Julia escape-time package
// Widths, register map, reset values, shared types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package jet_pkg;

    localparam int JET_FRAC_BITS  = 28;
    localparam int JET_COORD_BITS = 10;
    localparam int LIMB_BITS      = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int C_BITS        = 31;
    localparam int STEP_BITS     = 30;
    localparam int ITER_BITS     = 8;

    localparam logic [C_BITS-1:0]    C_REAL_RST   = 31'd0;
    localparam logic [C_BITS-1:0]    C_IMAG_RST   = 31'd268435456;
    localparam logic [STEP_BITS-1:0] STEP_X_RST   = 30'd1342177;
    localparam logic [STEP_BITS-1:0] STEP_Y_RST   = 30'd1342177;
    localparam logic [ITER_BITS-1:0] MAX_ITER_RST = 8'd255;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_C_REAL,
        REG_C_IMAG,
        REG_STEP_X,
        REG_STEP_Y,
        REG_MAX_ITER
    } reg_idx_t;

    typedef struct packed {
        logic [C_BITS-1:0]    c_real;
        logic [C_BITS-1:0]    c_imag;
        logic [STEP_BITS-1:0] step_x;
        logic [STEP_BITS-1:0] step_y;
        logic [ITER_BITS-1:0] max_iter;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_XX,
        OP_YY,
        OP_XY
    } op_t;

    typedef struct packed {
        logic vld;
        op_t  op;
    } mul_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_X,
        ST_LOAD_Y,
        ST_LOAD_END,
        ST_MUL,
        ST_CHECK,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/jet_cfg.sv */
// ----------------------------------------------------------------------------
// Julia escape-time configuration registers
// Decodes register writes and holds the Julia constant, steps and limit.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_cfg
    import jet_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          regs
);

    cfg_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.c_real   <= C_REAL_RST;
            regs_reg.c_imag   <= C_IMAG_RST;
            regs_reg.step_x   <= STEP_X_RST;
            regs_reg.step_y   <= STEP_Y_RST;
            regs_reg.max_iter <= MAX_ITER_RST;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_C_REAL:   regs_reg.c_real   <= cfg_data[C_BITS-1:0];
                REG_C_IMAG:   regs_reg.c_imag   <= cfg_data[C_BITS-1:0];
                REG_STEP_X:   regs_reg.step_x   <= cfg_data[STEP_BITS-1:0];
                REG_STEP_Y:   regs_reg.step_y   <= cfg_data[STEP_BITS-1:0];
                REG_MAX_ITER: regs_reg.max_iter <= cfg_data[ITER_BITS-1:0];
                default:      ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/jet_mul.sv */
// ----------------------------------------------------------------------------
// Julia escape-time shared multiplier
// Pipelined signed fixed-point multiply, floor-shifted by the fraction width
// (one less for x*y), from 32 by 32 partial products accumulated over cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_mul
    import jet_pkg::*;
#(
    parameter int FRAC_BITS = JET_FRAC_BITS,
    parameter int VAL_BITS  = FRAC_BITS + 3,
    parameter int RES_BITS  = FRAC_BITS + 7
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mul_ctl_t                   req_ctl,
    output logic                            req_ready,
    input  wire logic signed [VAL_BITS-1:0] req_a,
    input  wire logic signed [VAL_BITS-1:0] req_b,
    output mul_ctl_t                        rsp_ctl,
    output logic signed [RES_BITS-1:0]      rsp_data
);

    localparam int MAG_BITS  = VAL_BITS - 1;
    localparam int NLIMB     = (MAG_BITS + LIMB_BITS - 1) / LIMB_BITS;
    localparam int PAD_BITS  = NLIMB * LIMB_BITS;
    localparam int ACC_BITS  = 2 * PAD_BITS;
    localparam int IDX_BITS  = (NLIMB > 1) ? $clog2(NLIMB) : 1;
    localparam int POS_BITS  = $clog2(2 * NLIMB);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NLIMB - 1);

    logic [PAD_BITS-1:0]    a_mag_reg;
    logic [PAD_BITS-1:0]    b_mag_reg;
    logic                   a_vld_reg;
    logic                   a_neg_reg;
    op_t                    a_op_reg;
    logic [IDX_BITS-1:0]    i_reg;
    logic [IDX_BITS-1:0]    j_reg;

    logic [2*LIMB_BITS-1:0] p_reg;
    logic                   b_vld_reg;
    logic                   b_first_reg;
    logic                   b_last_reg;
    logic [POS_BITS-1:0]    b_pos_reg;
    logic                   b_neg_reg;
    op_t                    b_op_reg;

    logic [ACC_BITS-1:0]    acc_reg;
    logic                   c_vld_reg;
    logic                   c_neg_reg;
    op_t                    c_op_reg;

    logic                   d_vld_reg;
    op_t                    d_op_reg;
    logic signed [RES_BITS-1:0] d_data_reg;

    logic                   last_pp;
    logic                   accept;
    logic [MAG_BITS-1:0]    a_abs;
    logic [MAG_BITS-1:0]    b_abs;
    logic [LIMB_BITS-1:0]   a_limb;
    logic [LIMB_BITS-1:0]   b_limb;
    logic signed [ACC_BITS:0] prod_s;
    logic signed [ACC_BITS:0] prod_sh;

    assign last_pp   = (i_reg == LAST_IDX) && (j_reg == LAST_IDX);
    assign req_ready = !a_vld_reg || last_pp;
    assign accept    = req_ctl.vld && req_ready;

    assign a_abs  = req_a[VAL_BITS-1] ? MAG_BITS'(-req_a) : MAG_BITS'(req_a);
    assign b_abs  = req_b[VAL_BITS-1] ? MAG_BITS'(-req_b) : MAG_BITS'(req_b);
    assign a_limb = a_mag_reg[i_reg*LIMB_BITS +: LIMB_BITS];
    assign b_limb = b_mag_reg[j_reg*LIMB_BITS +: LIMB_BITS];

    assign prod_s  = c_neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign prod_sh = (c_op_reg == OP_XY) ? (prod_s >>> (FRAC_BITS - 1))
                                         : (prod_s >>> FRAC_BITS);

    assign rsp_ctl.vld = d_vld_reg;
    assign rsp_ctl.op  = d_op_reg;
    assign rsp_data    = d_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_vld_reg <= 1'b1;
                i_reg     <= '0;
                j_reg     <= '0;
            end
            else if (a_vld_reg)
            begin
                if (last_pp)
                begin
                    a_vld_reg <= 1'b0;
                end
                else if (j_reg == LAST_IDX)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg && b_last_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_mag_reg <= PAD_BITS'(a_abs);
            b_mag_reg <= PAD_BITS'(b_abs);
            a_neg_reg <= req_a[VAL_BITS-1] ^ req_b[VAL_BITS-1];
            a_op_reg  <= req_ctl.op;
        end

        p_reg       <= a_limb * b_limb;
        b_first_reg <= (i_reg == '0) && (j_reg == '0);
        b_last_reg  <= last_pp;
        b_pos_reg   <= POS_BITS'(i_reg) + POS_BITS'(j_reg);
        b_neg_reg   <= a_neg_reg;
        b_op_reg    <= a_op_reg;

        if (b_vld_reg)
        begin
            acc_reg <= (b_first_reg ? '0 : acc_reg)
                     + (ACC_BITS'(p_reg) << (b_pos_reg * LIMB_BITS));
            c_neg_reg <= b_neg_reg;
            c_op_reg  <= b_op_reg;
        end

        d_op_reg   <= c_op_reg;
        d_data_reg <= prod_sh[RES_BITS-1:0];
    end

endmodule

`default_nettype wire

/* rtl/jet_core.sv */
// ----------------------------------------------------------------------------
// Julia escape-time sequencer
// Maps a pixel to its start point, drives the shared multiplier through each
// iteration, updates z, tests the escape bound and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_core
    import jet_pkg::*;
#(
    parameter int FRAC_BITS  = JET_FRAC_BITS,
    parameter int COORD_BITS = JET_COORD_BITS,
    parameter int VAL_BITS   = FRAC_BITS + 3,
    parameter int RES_BITS   = FRAC_BITS + 7
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cfg_t                       cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [COORD_BITS-1:0]      col,
    input  wire logic [COORD_BITS-1:0]      row,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ITER_BITS-1:0]            iterations,
    output logic                            escaped,
    output mul_ctl_t                        req_ctl,
    input  wire logic                       req_ready,
    output logic signed [VAL_BITS-1:0]      req_a,
    output logic signed [VAL_BITS-1:0]      req_b,
    input  wire mul_ctl_t                   rsp_ctl,
    input  wire logic signed [RES_BITS-1:0] rsp_data
);

    localparam int XW      = (FRAC_BITS + 8 > COORD_BITS + 32) ? FRAC_BITS + 8
                                                               : COORD_BITS + 32;
    localparam int SP_BITS = COORD_BITS + STEP_BITS;
    localparam logic signed [XW-1:0] ONE_X =
        {{(XW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [XW-1:0] LIM_X =
        {{(XW-FRAC_BITS-2){1'b0}}, {(FRAC_BITS+2){1'b1}}};
    localparam logic signed [XW-1:0] NEG_LIM_X = -LIM_X;
    localparam logic signed [RES_BITS:0] FOUR_M =
        {{(RES_BITS-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};
    localparam logic [1:0] ISSUE_ALL = 2'd3;

    state_t                      state_reg;
    state_t                      state_next;
    logic [1:0]                  issued_reg;
    logic [2:0]                  got_reg;
    logic                        first_reg;
    logic                        out_valid_reg;

    logic [COORD_BITS-1:0]       col_reg;
    logic [COORD_BITS-1:0]       row_reg;
    logic [SP_BITS-1:0]          sp_reg;
    logic signed [VAL_BITS-1:0]  x_reg;
    logic signed [VAL_BITS-1:0]  y_reg;
    logic signed [RES_BITS-1:0]  xx_reg;
    logic signed [RES_BITS-1:0]  yy_reg;
    logic signed [RES_BITS-1:0]  xy_reg;
    logic [ITER_BITS-1:0]        k_reg;
    logic                        esc_reg;
    logic [ITER_BITS-1:0]        iter_out_reg;
    logic                        esc_out_reg;

    logic                        out_load;
    logic signed [XW-1:0]        start_v;
    logic signed [XW-1:0]        upd_x;
    logic signed [XW-1:0]        upd_y;
    logic signed [RES_BITS:0]    mag2;
    logic                        mag2_hit;

    function automatic logic signed [VAL_BITS-1:0] sat_val(input logic signed [XW-1:0] v);
        logic signed [VAL_BITS-1:0] r;
        if (v > LIM_X)
            r = LIM_X[VAL_BITS-1:0];
        else if (v < NEG_LIM_X)
            r = NEG_LIM_X[VAL_BITS-1:0];
        else
            r = v[VAL_BITS-1:0];
        return r;
    endfunction

    assign start_v  = $signed(XW'(sp_reg)) - ONE_X;
    assign upd_x    = XW'(xx_reg) - XW'(yy_reg) + XW'($signed(cfg.c_real));
    assign upd_y    = XW'(xy_reg) + XW'($signed(cfg.c_imag));
    assign mag2     = (RES_BITS+1)'(xx_reg) + (RES_BITS+1)'(yy_reg);
    assign mag2_hit = mag2 >= FOUR_M;

    assign out_valid  = out_valid_reg;
    assign iterations = iter_out_reg;
    assign escaped    = esc_out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_LOAD_X;
            ST_LOAD_X:
                state_next = ST_LOAD_Y;
            ST_LOAD_Y:
                state_next = ST_LOAD_END;
            ST_LOAD_END:
                state_next = (cfg.max_iter == '0) ? ST_DONE : ST_MUL;
            ST_MUL:
                if (&got_reg)
                    state_next = first_reg ? ST_UPDATE : ST_CHECK;
            ST_CHECK:
                state_next = (mag2_hit || (k_reg == cfg.max_iter)) ? ST_DONE : ST_UPDATE;
            ST_UPDATE:
                state_next = ST_MUL;
            ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_load    = 1'b0;
        req_ctl.vld = 1'b0;
        req_ctl.op  = OP_XX;
        case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_MUL:
                if (issued_reg != ISSUE_ALL)
                begin
                    req_ctl.vld = 1'b1;
                    req_ctl.op  = op_t'(issued_reg);
                end
            ST_DONE:
                out_load = !out_valid_reg || out_ready;
            default:
                ;
        endcase

        case (req_ctl.op)
            OP_XX:
            begin
                req_a = x_reg;
                req_b = x_reg;
            end
            OP_YY:
            begin
                req_a = y_reg;
                req_b = y_reg;
            end
            default:
            begin
                req_a = x_reg;
                req_b = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= '0;
            got_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == ST_LOAD_END) || (state_reg == ST_UPDATE))
            begin
                issued_reg <= '0;
                got_reg    <= '0;
            end
            else
            begin
                if (req_ctl.vld && req_ready)
                    issued_reg <= issued_reg + 1'b1;
                if (rsp_ctl.vld)
                    got_reg[rsp_ctl.op] <= 1'b1;
            end

            if (state_reg == ST_LOAD_END)
                first_reg <= 1'b1;
            else if (state_reg == ST_UPDATE)
                first_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    col_reg <= col;
                    row_reg <= row;
                end
            ST_LOAD_X:
                sp_reg <= col_reg * cfg.step_x;
            ST_LOAD_Y:
            begin
                x_reg  <= sat_val(start_v);
                sp_reg <= row_reg * cfg.step_y;
            end
            ST_LOAD_END:
            begin
                y_reg   <= sat_val(start_v);
                k_reg   <= '0;
                esc_reg <= 1'b0;
            end
            ST_CHECK:
                esc_reg <= mag2_hit;
            ST_UPDATE:
            begin
                x_reg <= sat_val(upd_x);
                y_reg <= sat_val(upd_y);
                k_reg <= k_reg + 1'b1;
            end
            default:
                ;
        endcase

        if (rsp_ctl.vld)
        begin
            case (rsp_ctl.op)
                OP_XX:   xx_reg <= rsp_data;
                OP_YY:   yy_reg <= rsp_data;
                default: xy_reg <= rsp_data;
            endcase
        end

        if (out_load)
        begin
            iter_out_reg <= k_reg;
            esc_out_reg  <= esc_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/julia_escape_time.sv */
// Julia-set escape-time pixel engine. Each input transaction is one pixel
// (col, row); the engine maps it to z = (col*step_x - 1, row*step_y - 1) in
// two's-complement fixed point with FRAC_BITS fraction bits, iterates
// z = z^2 + c, and after every iteration stops once |z|^2 >= 4 or max_iter
// iterations have run, returning the count and an escape flag. One pixel is
// in flight at a time: in_ready is low from acceptance until the result is
// loaded into the output register, which then frees the input for the next
// pixel while the result waits. Setup runs through ST_LOAD_X, ST_LOAD_Y and
// ST_LOAD_END; each iteration then sends the three products x*x, y*y and
// x*y through one shared pipelined multiplier, plus one check step (skipped
// on the first pass) and one update step. The defaults are 28 fraction bits
// and max_iter 255. With FRAC_BITS from 31 to 62 each product is built from
// four 32 by 32 partial products. Registers are to be written only while the
// engine is idle.
// ----------------------------------------------------------------------------
// Julia escape-time top level
// Configuration registers, iteration sequencer and shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time
    import jet_pkg::*;
#(
    parameter int FRAC_BITS  = JET_FRAC_BITS,
    parameter int COORD_BITS = JET_COORD_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [COORD_BITS-1:0]    col,
    input  wire logic [COORD_BITS-1:0]    row,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [ITER_BITS-1:0]          iterations,
    output logic                          escaped
);

    localparam int VAL_BITS = FRAC_BITS + 3;
    localparam int RES_BITS = FRAC_BITS + 7;

    cfg_t                       regs;
    mul_ctl_t                   req_ctl;
    logic                       req_ready;
    logic signed [VAL_BITS-1:0] req_a;
    logic signed [VAL_BITS-1:0] req_b;
    mul_ctl_t                   rsp_ctl;
    logic signed [RES_BITS-1:0] rsp_data;

    jet_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    jet_mul #(
        .FRAC_BITS (FRAC_BITS),
        .VAL_BITS  (VAL_BITS),
        .RES_BITS  (RES_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ctl   (req_ctl),
        .req_ready (req_ready),
        .req_a     (req_a),
        .req_b     (req_b),
        .rsp_ctl   (rsp_ctl),
        .rsp_data  (rsp_data)
    );

    jet_core #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS),
        .VAL_BITS   (VAL_BITS),
        .RES_BITS   (RES_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (regs),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .col        (col),
        .row        (row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .iterations (iterations),
        .escaped    (escaped),
        .req_ctl    (req_ctl),
        .req_ready  (req_ready),
        .req_a      (req_a),
        .req_b      (req_b),
        .rsp_ctl    (rsp_ctl),
        .rsp_data   (rsp_data)
    );

endmodule

`default_nettype wire

/* rtl/jet_checker.sv */
// ----------------------------------------------------------------------------
// Julia escape-time port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "julia_escape_time_defines.svh"

module jet_checker
    import jet_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [ITER_BITS-1:0] iterations,
    input wire logic                 escaped
);

    `JET_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `JET_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(iterations) && $stable(escaped), "result changed while stalled")
    `JET_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "pixel accepted while another is in flight")
    `JET_ASSERT_IMP(a_escape_counted, out_valid && escaped, iterations != '0, "escape reported with no iteration")

endmodule

bind julia_escape_time jet_checker u_jet_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .iterations (iterations),
    .escaped    (escaped)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia escape-time pixel engine testbench
// Streams pixel transactions through the engine under changing register
// settings and checks every iteration count and escape flag against an
// in-bench fixed-point model of the z = z^2 + c iteration. Both channels
// stall at random; one long output stall backs the engine up to its input.
// ----------------------------------------------------------------------------

module tb;
    import jet_pkg::*;

    localparam int  Q_ONE           = 1 << JET_FRAC_BITS;
    localparam int  RX_HOLD_CYCLES  = 3000;
    localparam int  STALL_LIMIT     = 40000;
    localparam int  CHUNKS_PER_MODE = 14;

    typedef struct packed {
        logic [JET_COORD_BITS-1:0] col;
        logic [JET_COORD_BITS-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [ITER_BITS-1:0] iterations;
        logic                 escaped;
    } escape_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [JET_COORD_BITS-1:0] col = '0;
    logic [JET_COORD_BITS-1:0] row = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [ITER_BITS-1:0]     iterations;
    logic                     escaped;

    pixel_t         pixel_q[$];
    escape_result_t escape_q[$];

    longint               c_real_q   = longint'($signed(C_REAL_RST));
    longint               c_imag_q   = longint'($signed(C_IMAG_RST));
    logic [STEP_BITS-1:0] step_x_q   = STEP_X_RST;
    logic [STEP_BITS-1:0] step_y_q   = STEP_Y_RST;
    logic [ITER_BITS-1:0] max_iter_q = MAX_ITER_RST;

    int send_idle_pct = 10;
    int recv_idle_pct = 64;
    int rx_hold_ask   = 0;
    int rx_hold_seen  = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int stall_cycles  = 0;
    bit offer_busy    = 1'b0;

    julia_escape_time dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .col        (col),
        .row        (row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .iterations (iterations),
        .escaped    (escaped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_q4(longint v);
        longint lim;
        lim = (longint'(4) <<< JET_FRAC_BITS) - 1;
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b, int sh);
        return (a * b) >>> sh;
    endfunction

    function automatic escape_result_t predict_escape(logic [JET_COORD_BITS-1:0] px_col,
                                                      logic [JET_COORD_BITS-1:0] px_row);
        longint         one;
        longint         four;
        longint         x;
        longint         y;
        longint         xx;
        longint         yy;
        longint         xy2;
        longint         mag2;
        int             k;
        escape_result_t res;
        one  = longint'(1) <<< JET_FRAC_BITS;
        four = longint'(4) <<< JET_FRAC_BITS;
        x    = clamp_q4(longint'(px_col) * longint'(step_x_q) - one);
        y    = clamp_q4(longint'(px_row) * longint'(step_y_q) - one);
        mag2 = 0;
        k    = 0;
        while (k < int'(max_iter_q) && mag2 < four)
        begin
            xx   = fx_mul(x, x, JET_FRAC_BITS);
            yy   = fx_mul(y, y, JET_FRAC_BITS);
            xy2  = fx_mul(x, y, JET_FRAC_BITS - 1);
            x    = clamp_q4(xx - yy + c_real_q);
            y    = clamp_q4(xy2 + c_imag_q);
            mag2 = fx_mul(x, x, JET_FRAC_BITS) + fx_mul(y, y, JET_FRAC_BITS);
            k++;
        end
        res.iterations = ITER_BITS'(k);
        res.escaped    = (mag2 >= four);
        return res;
    endfunction

    // Pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            col        <= '0;
            row        <= '0;
            offer_busy = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                escape_q.push_back(predict_escape(col, row));
                offer_busy = 1'b0;
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt        = pixel_q.pop_front();
                    in_valid   <= 1'b1;
                    col        <= nxt.col;
                    row        <= nxt.row;
                    offer_busy = 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        escape_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (escape_q.size() == 0)
                begin
                    $error("unexpected result: iterations %0d escaped %0d", iterations, escaped);
                    err_count++;
                end
                else
                begin
                    want = escape_q.pop_front();
                    if (iterations !== want.iterations)
                    begin
                        $error("iterations: expected %0d, actual %0d", want.iterations, iterations);
                        err_count++;
                    end
                    if (escaped !== want.escaped)
                    begin
                        $error("escaped: expected %0d, actual %0d", want.escaped, escaped);
                        err_count++;
                    end
                end
            end
            if (rx_hold_seen != rx_hold_ask)
            begin
                rx_hold_seen = rx_hold_ask;
                hold_left    = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pixel_q.size() != 0 || offer_busy || escape_q.size() != 0);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_C_REAL:   c_real_q   = longint'($signed(value[C_BITS-1:0]));
            REG_C_IMAG:   c_imag_q   = longint'($signed(value[C_BITS-1:0]));
            REG_STEP_X:   step_x_q   = value[STEP_BITS-1:0];
            REG_STEP_Y:   step_y_q   = value[STEP_BITS-1:0];
            REG_MAX_ITER: max_iter_q = value[ITER_BITS-1:0];
            default:      ;
        endcase
    endtask

    task automatic apply_config(input int c_re, input int c_im, input int sx, input int sy,
                                input int lim);
        wait_drained();
        write_reg(REG_C_REAL, c_re);
        write_reg(REG_C_IMAG, c_im);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_MAX_ITER, lim);
    endtask

    task automatic push_pixel(input int px_col, input int px_row);
        pixel_t p;
        p.col = JET_COORD_BITS'(px_col);
        p.row = JET_COORD_BITS'(px_row);
        pixel_q.push_back(p);
    endtask

    function automatic int pick_coord();
        if ($urandom_range(99) < 15)
            return $urandom_range(1) ? (1 << JET_COORD_BITS) - 1 : 0;
        return $urandom_range(0, (1 << JET_COORD_BITS) - 1);
    endfunction

    function automatic int pick_c();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return (int'($urandom_range(2)) - 1) * 2 * Q_ONE;
        if (r < 60)
            return int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        return int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
    endfunction

    function automatic int pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return (2 * Q_ONE) / int'($urandom_range(64, 1024));
        if (r < 70)
            return $urandom_range(0, 2 * Q_ONE);
        if (r < 85)
            return $urandom_range(0, 1 << 18);
        return $urandom_range(1) ? 2 * Q_ONE : 0;
    endfunction

    function automatic int pick_limit();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 16);
        if (r < 90)
            return $urandom_range(17, 64);
        if (r < 95)
            return 255;
        return $urandom_range(65, 254);
    endfunction

    task automatic queue_pixels(input int n);
        @(negedge clk);
        repeat (n)
            push_pixel(pick_coord(), pick_coord());
    endtask

    task automatic run_chunk(input bit long_hold);
        int lim;
        int n;
        lim = long_hold ? 4 : pick_limit();
        apply_config(pick_c(), pick_c(), pick_step(), pick_step(), lim);
        n = (lim > 64) ? 12 : 50;
        queue_pixels(n / 2);
        if (long_hold)
            rx_hold_ask++;
        // hold the sender until the engine has emptied out
        wait_drained();
        queue_pixels(n - n / 2);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: corners, the bounded center orbit of c = i
        @(negedge clk);
        push_pixel(0, 0);
        push_pixel(1023, 1023);
        push_pixel(200, 200);
        push_pixel(0, 1023);
        push_pixel(1023, 0);

        // no iterations at all
        apply_config(0, Q_ONE, 1342177, 1342177, 0);
        push_pixel(5, 7);
        push_pixel(1023, 1023);

        // far start points and escape on the only allowed iteration
        apply_config(2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 1);
        push_pixel(1023, 1023);
        push_pixel(0, 0);
        push_pixel(1, 0);
        push_pixel(3, 2);

        // zero steps: every pixel starts at (-1, -1)
        apply_config(-2 * Q_ONE, 2 * Q_ONE, 0, 0, 8);
        push_pixel(1023, 0);
        push_pixel(0, 1023);
        push_pixel(512, 512);

        // c = 0 with the origin at the center of a 1024 grid
        apply_config(0, 0, Q_ONE / 512, Q_ONE / 512, 255);
        push_pixel(512, 512);
        push_pixel(1023, 512);
        push_pixel(0, 0);
        push_pixel(700, 300);
        push_pixel(1023, 1023);

        for (int mode = 0; mode < 3; mode++)
        begin
            wait_drained();
            @(negedge clk);
            case (mode)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int p = 0; p < CHUNKS_PER_MODE; p++)
                run_chunk(mode == 2 && p == 0);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (err_count == 0 && escape_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/jet_pkg.sv
rtl/jet_cfg.sv
rtl/jet_mul.sv
rtl/jet_core.sv
rtl/julia_escape_time.sv
rtl/jet_checker.sv
tb/tb.sv
